/* design/ptmf_pkg.sv */
// shared constants and types for the trimmed-mean ph filter
package ptmf_pkg;

    // default ring depth
    localparam int WINDOW_DEF = 32;

    // field widths
    localparam int ADC_W    = 12;
    localparam int PH_W     = 16;
    localparam int SUPPLY_W = 13;
    localparam int OFFSET_W = 17;
    localparam int ALPHA_W  = 17;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 17;

    // quotient of the scaling division never reaches 2^17 (mean <= 4095, supply < 8192)
    localparam int QUO_W = 17;

    // ph_q = 7 * mean * supply / 2000  (3.5 pH/V, mV to V, 4096 scaling cancels)
    localparam int PH_GAIN   = 7;
    localparam int DEN_SCALE = 2000;

    // plain mean below this window size, trimmed mean from it upwards
    localparam int TRIM_MIN = 5;

    localparam logic [PH_W-1:0]    PH_MAX     = 16'd57344;
    localparam logic [ALPHA_W-1:0] ALPHA_ONE  = 17'd65536;
    localparam logic [ADC_W-1:0]   ADC_MAX    = 12'hFFF;

    // reset values of the configuration registers
    localparam logic [SUPPLY_W-1:0] SUPPLY_RST = 13'd3300;
    localparam logic [OFFSET_W-1:0] OFFSET_RST = 17'd0;
    localparam logic [ALPHA_W-1:0]  ALPHA_RST  = 17'd32768;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SUPPLY_MV    = 2'd0,
        REG_PH_OFFSET    = 2'd1,
        REG_SMOOTH_ALPHA = 2'd2
    } t_cfg_reg;

endpackage

/* design/ph_trimmed_mean_ema_filter.sv */
// top level: ph probe filter, ring window, trimmed mean, scaling and ema
//
//  channel   direction  handshake                     payload
//  -------   ---------  ----------------------------  ---------------------------------
//  sample    in         i_in_valid / o_in_stall       i_adc_sample
//  result    out        o_out_valid / i_out_stall     o_smoothed_ph, o_clamped_ph
//  config    in         i_cfg_valid / o_cfg_ready     i_cfg_index, i_cfg_data
//
// a new sample is taken only once the previous one is through the sequencer;
// the first result after reset skips the ema
// each sample starts a window sweep through the single ram read port;
// the constant division is a reciprocal multiply
// reset is synchronous: ring reads as zero via a fill count, no clearing pass
// a finished result waits in the output register while the next sample is taken;
// the sequencer holds at its last step only if that register is still occupied
// config is always ready, and is only to be written while the block is idle
module ph_trimmed_mean_ema_filter #(
    parameter int WINDOW = ptmf_pkg::WINDOW_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // sample channel
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [ptmf_pkg::ADC_W-1:0]        i_adc_sample,
    // result channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [ptmf_pkg::PH_W-1:0]         o_smoothed_ph,
    output logic [ptmf_pkg::PH_W-1:0]         o_clamped_ph,
    // config write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [ptmf_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [ptmf_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    // ---------------------------------------------------------------------
    // derived sizes
    // ---------------------------------------------------------------------
    localparam int ADC_W = ptmf_pkg::ADC_W;
    localparam int PH_W  = ptmf_pkg::PH_W;
    localparam int AW    = (WINDOW > 1) ? $clog2(WINDOW) : 1;   // ring address
    localparam int CW    = $clog2(WINDOW + 1);                  // count up to WINDOW
    localparam int SW    = ADC_W + $clog2(WINDOW);              // window sum
    localparam int MA_W  = (SW > ptmf_pkg::ALPHA_W) ? SW : ptmf_pkg::ALPHA_W;
    localparam int MB_W  = PH_W;
    localparam int P_W   = MA_W + MB_W;
    localparam int NUM_W = P_W + 3;                             // room for the x7
    localparam int QUO_W = ptmf_pkg::QUO_W;
    localparam int DIVR  = (WINDOW < ptmf_pkg::TRIM_MIN) ? WINDOW : WINDOW - 2;
    localparam int DEN   = ptmf_pkg::DEN_SCALE * DIVR;
    localparam int CUR_W = QUO_W + 2;                           // signed sum with offset
    localparam int ACC_W = 2 * PH_W + 1;                        // ema accumulator

    // ---------------------------------------------------------------------
    // sequencer
    // ---------------------------------------------------------------------
    typedef enum logic [3:0] {
        S_IDLE,
        S_SWEEP,     // read every ring entry, sum, min, max
        S_TRIM,      // drop one min and one max (plain sum below TRIM_MIN)
        S_MUL,       // sum * supply
        S_SCALE,     // x7, launch divider
        S_DIV,       // wait for quotient
        S_CLAMP,     // add offset, clamp to 0..14
        S_EMA_A,     // alpha * current
        S_EMA_B,     // (1 - alpha) * last
        S_EMA_SUM,   // add with rounding
        S_DONE       // hand over to output register
    } t_state;

    t_state r_state, n_state;

    logic [CW-1:0]    r_cnt, n_cnt;
    logic             r_rdv, n_rdv;
    logic             r_live, n_live;
    logic [SW-1:0]    r_sum, n_sum;
    logic [ADC_W-1:0] r_lo, n_lo;
    logic [ADC_W-1:0] r_hi, n_hi;
    logic [SW-1:0]    r_s, n_s;
    logic [AW-1:0]    r_wslot, n_wslot;
    logic [CW-1:0]    r_fill, n_fill;
    logic             r_first, n_first;
    logic [PH_W-1:0]  r_last, n_last;
    logic [PH_W-1:0]  r_clamped, n_clamped;
    logic [PH_W-1:0]  r_smoothed, n_smoothed;
    logic [ACC_W-2:0] r_acc, n_acc;
    logic             r_out_valid, n_out_valid;
    logic [PH_W-1:0]  r_out_smoothed, n_out_smoothed;
    logic [PH_W-1:0]  r_out_clamped, n_out_clamped;

    // configuration registers
    logic [ptmf_pkg::SUPPLY_W-1:0] r_supply;
    logic [ptmf_pkg::OFFSET_W-1:0] r_offset;
    logic [ptmf_pkg::ALPHA_W-1:0]  r_alpha;

    // datapath wires
    logic             accept;
    logic             ram_re;
    logic [ADC_W-1:0] ram_rdata;
    logic [ADC_W-1:0] sample_v;
    logic [MA_W-1:0]  mul_a;
    logic [MB_W-1:0]  mul_b;
    logic [P_W-1:0]   mul_p;
    logic [NUM_W-1:0] num;
    logic             div_start;
    logic             div_done;
    logic [QUO_W-1:0] div_quo;
    logic [CUR_W-1:0] cur;
    logic [ACC_W-1:0] ema_sum;
    logic [ptmf_pkg::ALPHA_W-1:0] alpha_c;

    assign accept      = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    // ring storage
    ptmf_ram #(
        .WIDTH (ADC_W),
        .DEPTH (WINDOW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (accept),
        .i_waddr (r_wslot),
        .i_wdata (i_adc_sample),
        .i_re    (ram_re),
        .i_raddr (r_cnt[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    assign ram_re = (r_state == S_SWEEP) && (r_cnt != CW'(WINDOW));

    // entries never written count as zero
    assign sample_v = r_live ? ram_rdata : '0;

    // shared multiplier, operands picked by the step in progress
    assign alpha_c = ptmf_pkg::ALPHA_ONE - r_alpha;

    always_comb begin
        case (r_state)
            S_EMA_A: begin
                mul_a = MA_W'(r_alpha);
                mul_b = r_clamped;
            end
            S_EMA_B: begin
                mul_a = MA_W'(alpha_c);
                mul_b = r_last;
            end
            default: begin
                mul_a = MA_W'(r_s);
                mul_b = MB_W'(r_supply);
            end
        endcase
    end

    ptmf_mul #(
        .A_W (MA_W),
        .B_W (MB_W)
    ) u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    // x7 as x8 minus x1
    assign num       = (NUM_W'(mul_p) << 3) - NUM_W'(mul_p);
    assign div_start = (r_state == S_SCALE);

    ptmf_div #(
        .NUM_W (NUM_W),
        .QUO_W (QUO_W),
        .DEN   (DEN)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (num),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // raw ph plus sign-extended offset
    assign cur = {2'b00, div_quo} + {{(CUR_W - ptmf_pkg::OFFSET_W){r_offset[ptmf_pkg::OFFSET_W-1]}},
                                     r_offset};

    // ema with round half up
    assign ema_sum = {1'b0, r_acc} + {1'b0, mul_p[ACC_W-2:0]} + ACC_W'(32768);

    always_comb begin
        n_state        = r_state;
        n_cnt          = r_cnt;
        n_rdv          = 1'b0;
        n_live         = r_live;
        n_sum          = r_sum;
        n_lo           = r_lo;
        n_hi           = r_hi;
        n_s            = r_s;
        n_wslot        = r_wslot;
        n_fill         = r_fill;
        n_first        = r_first;
        n_last         = r_last;
        n_clamped      = r_clamped;
        n_smoothed     = r_smoothed;
        n_acc          = r_acc;
        n_out_valid    = r_out_valid && i_out_stall;
        n_out_smoothed = r_out_smoothed;
        n_out_clamped  = r_out_clamped;

        // accumulate the entry read in the previous cycle
        if (r_rdv) begin
            n_sum = r_sum + SW'(sample_v);
            if (sample_v < r_lo) begin
                n_lo = sample_v;
            end
            if (sample_v > r_hi) begin
                n_hi = sample_v;
            end
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_wslot = (r_wslot == AW'(WINDOW - 1)) ? '0 : r_wslot + 1'b1;
                    if (r_fill != CW'(WINDOW)) begin
                        n_fill = r_fill + 1'b1;
                    end
                    n_cnt   = '0;
                    n_sum   = '0;
                    n_lo    = ptmf_pkg::ADC_MAX;
                    n_hi    = '0;
                    n_state = S_SWEEP;
                end
            end
            S_SWEEP: begin
                if (r_cnt != CW'(WINDOW)) begin
                    n_rdv  = 1'b1;
                    n_live = (r_cnt < r_fill);
                    n_cnt  = r_cnt + 1'b1;
                end else begin
                    n_state = S_TRIM;
                end
            end
            S_TRIM: begin
                if (WINDOW < ptmf_pkg::TRIM_MIN) begin
                    n_s = r_sum;
                end else begin
                    n_s = r_sum - SW'(r_lo) - SW'(r_hi);
                end
                n_state = S_MUL;
            end
            S_MUL: begin
                n_state = S_SCALE;
            end
            S_SCALE: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_CLAMP;
                end
            end
            S_CLAMP: begin
                if (cur[CUR_W-1]) begin
                    n_clamped = '0;
                end else if (cur > CUR_W'(ptmf_pkg::PH_MAX)) begin
                    n_clamped = ptmf_pkg::PH_MAX;
                end else begin
                    n_clamped = cur[PH_W-1:0];
                end
                if (r_first) begin
                    // first result passes straight through
                    n_smoothed = n_clamped;
                    n_last     = n_clamped;
                    n_first    = 1'b0;
                    n_state    = S_DONE;
                end else begin
                    n_state = S_EMA_A;
                end
            end
            S_EMA_A: begin
                n_state = S_EMA_B;
            end
            S_EMA_B: begin
                n_acc   = mul_p[ACC_W-2:0];
                n_state = S_EMA_SUM;
            end
            S_EMA_SUM: begin
                n_smoothed = ema_sum[2*PH_W-1:PH_W];
                n_last     = ema_sum[2*PH_W-1:PH_W];
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid    = 1'b1;
                    n_out_smoothed = r_smoothed;
                    n_out_clamped  = r_clamped;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_rdv       <= 1'b0;
            r_live      <= 1'b0;
            r_wslot     <= '0;
            r_fill      <= '0;
            r_first     <= 1'b1;
            r_last      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_rdv       <= n_rdv;
            r_live      <= n_live;
            r_wslot     <= n_wslot;
            r_fill      <= n_fill;
            r_first     <= n_first;
            r_last      <= n_last;
            r_out_valid <= n_out_valid;
        end
        r_sum          <= n_sum;
        r_lo           <= n_lo;
        r_hi           <= n_hi;
        r_s            <= n_s;
        r_clamped      <= n_clamped;
        r_smoothed     <= n_smoothed;
        r_acc          <= n_acc;
        r_out_smoothed <= n_out_smoothed;
        r_out_clamped  <= n_out_clamped;
    end

    // ---------------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_supply <= ptmf_pkg::SUPPLY_RST;
            r_offset <= ptmf_pkg::OFFSET_RST;
            r_alpha  <= ptmf_pkg::ALPHA_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                ptmf_pkg::REG_SUPPLY_MV: begin
                    r_supply <= i_cfg_data[ptmf_pkg::SUPPLY_W-1:0];
                end
                ptmf_pkg::REG_PH_OFFSET: begin
                    r_offset <= i_cfg_data[ptmf_pkg::OFFSET_W-1:0];
                end
                ptmf_pkg::REG_SMOOTH_ALPHA: begin
                    // weights above 1.0 are dropped
                    if (i_cfg_data[ptmf_pkg::ALPHA_W-1:0] <= ptmf_pkg::ALPHA_ONE) begin
                        r_alpha <= i_cfg_data[ptmf_pkg::ALPHA_W-1:0];
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_smoothed_ph = r_out_smoothed;
    assign o_clamped_ph  = r_out_clamped;

endmodule

/* design/ptmf_ram.sv */
// generic single-write, single-read ram with registered read data
module ptmf_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* design/ptmf_mul.sv */
// shared unsigned multiplier with registered product
module ptmf_mul #(
    parameter int A_W = 20,
    parameter int B_W = 16
) (
    input  logic             i_clk,
    input  logic [A_W-1:0]   i_a,
    input  logic [B_W-1:0]   i_b,
    output logic [A_W+B_W-1:0] o_p
);

    logic [A_W+B_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= (A_W+B_W)'(i_a) * (A_W+B_W)'(i_b);
    end

    assign o_p = r_p;

endmodule

/* design/ptmf_div.sv */
// division by a constant as a reciprocal multiply, shifted numerator and product both registered
module ptmf_div #(
    parameter int NUM_W = 36,
    parameter int QUO_W = 17,
    parameter int DEN   = 60000
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    output logic             o_done,
    output logic [QUO_W-1:0] o_quo
);

    // trailing zero bits of the divisor
    function automatic int low_zeros(input longint unsigned v);
        int n;
        longint unsigned t;
        n = 0;
        t = v;
        while (t != 0 && t[0] == 1'b0) begin
            t = t >> 1;
            n++;
        end
        return n;
    endfunction

    // divisor = ODD * 2^TZ; the power of two is a shift, the odd part a multiply
    localparam int TZ  = low_zeros(64'(DEN));
    localparam longint unsigned ODD = 64'(DEN) >> TZ;
    localparam int OW  = $clog2(ODD);
    // quotient fits QUO_W bits, so the shifted numerator stays below 2^(QUO_W+OW)
    localparam int X_W = QUO_W + OW;
    localparam int K   = X_W + OW;
    localparam int M_W = QUO_W + OW + 1;
    localparam int P_W = X_W + M_W;
    // rounded-up reciprocal; its error times the largest numerator stays under 2^K
    localparam longint unsigned M_FULL = ((64'd1 << K) + ODD - 64'd1) / ODD;
    localparam logic [M_W-1:0] M_C = M_W'(M_FULL);

    logic [X_W-1:0] r_x;
    logic           r_x_v;
    logic [P_W-1:0] r_p;
    logic           r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_v  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_x_v  <= i_start;
            r_done <= r_x_v;
        end
        if (i_start) begin
            r_x <= i_num[TZ +: X_W];
        end
        if (r_x_v) begin
            r_p <= P_W'(r_x) * P_W'(M_C);
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_p[K +: QUO_W];

endmodule
